>>> hdl/stpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stpg_pkg;

	// default datapath widths
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int FREQ_WIDTH_DEF  = 17;

	// ramp length register is always 16 bits
	localparam int RAMP_W = 16;

	// configuration port
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_FREQ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_FREQ  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_CEIL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_NUM    = 3'd6;

	// register reset values
	localparam int RST_TOTAL_STEPS = 14400;
	localparam int RST_CRUISE_FREQ = 720;
	localparam int RST_START_FREQ  = 300;
	localparam int RST_RAMP_STEPS  = 300;
	localparam int RST_FREQ_CEIL   = 1500;
	localparam int RST_HALF_NUM    = 500000;

endpackage

`default_nettype wire

>>> hdl/stepper_trapezoid_pulse_gen.sv
// Sequencing: a tick word inside a half period passes through S_TICK and S_PUSH, an idle tick
// goes straight to S_PUSH; S_PUSH holds while the output is stalled. A word that opens a ramp step
// runs one shared restoring divider for the ramp point (FREQ_WIDTH+16 iterations), then for the
// half period (COUNT_WIDTH iterations); a cruise step skips the ramp divide.
// One word at a time: s_tready is high only in idle, until the result is loaded.
// Reset: arst_n clears the sequencer and move state; registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_pulse_gen #(
	parameter int COUNT_WIDTH = stpg_pkg::COUNT_WIDTH_DEF,
	parameter int FREQ_WIDTH  = stpg_pkg::FREQ_WIDTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// tick stream; tdata: [0] start_req
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [7:0]                            s_tdata,
	// result stream; tdata: [0] pulse_level, [1] dir_level, [2] busy_res,
	// [3] done_res, then step_index, then step_freq, zero fill
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [((4+COUNT_WIDTH+FREQ_WIDTH+7)/8)*8-1:0] m_tdata,
	// configuration write channel
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [stpg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [((COUNT_WIDTH > FREQ_WIDTH) ? COUNT_WIDTH : FREQ_WIDTH)-1:0] cfg_data
);

	localparam int C   = COUNT_WIDTH;
	localparam int F   = FREQ_WIDTH;
	localparam int RW  = stpg_pkg::RAMP_W;
	localparam int OW  = ((4 + C + F + 7) / 8) * 8;
	// divider sizes
	localparam int DVW = (F > RW) ? F : RW;
	localparam int NW1 = F + RW;
	localparam int NW  = (NW1 > C) ? NW1 : C;
	localparam int CW  = $clog2(NW + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TICK,
		S_PICK,
		S_LD1,
		S_DIV1,
		S_FREQ,
		S_DIV2,
		S_HALF,
		S_PUSH
	} state_t;

	state_t state_q;

	// configuration registers
	logic [C-1:0]  total_q;
	logic [F-1:0]  cruise_q;
	logic          dir_q;
	logic [F-1:0]  startf_q;
	logic [RW-1:0] ramp_q;
	logic [F-1:0]  ceil_q;
	logic [C-1:0]  num_q;

	// move state
	logic          running_q;
	logic          phase_q;
	logic [C-1:0]  step_q;
	logic [C-1:0]  timer_q;
	logic [C-1:0]  hpt_q;
	logic [F-1:0]  clamp_q;
	logic [F-1:0]  freq_q;
	logic          tick_after_q;

	// pending result word
	logic          res_pulse_q;
	logic          res_busy_q;
	logic          res_done_q;
	logic [C-1:0]  res_idx_q;
	logic [F-1:0]  res_freq_q;

	// output register
	logic          m_valid_q;
	logic [OW-1:0] m_data_q;

	// shared divider
	logic [NW-1:0]    dvd_q;
	logic [DVW-1:0]   den_q;
	logic [DVW-1:0]   rem_q;
	logic [NW-1:0]    quo_q;
	logic [CW-1:0]    cnt_q;
	logic [NW1-1:0]   prod_q;

	logic [DVW+1:0]   trial;
	logic             take;

	logic             in_acc;
	logic             start_req;
	logic [F-1:0]     cruise_lim;
	logic [F-1:0]     cruise_clamp;
	logic [F-1:0]     span;
	logic             in_up;
	logic             in_dn;
	logic [C-1:0]     rem_steps;
	logic [RW-1:0]    mul_x;
	logic [C-1:0]     timer_dec;
	logic             last_step;
	logic [F-1:0]     ramp_freq;
	logic [F-1:0]     cruise_fix;
	logic [C-1:0]     half_ticks;
	logic             out_load;

	assign in_acc    = s_tvalid && s_tready;
	assign start_req = s_tdata[0];
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_load  = (state_q == S_PUSH) && (!m_valid_q || m_tready);

	// restoring divide step
	always_comb begin
		trial = {1'b0, rem_q, dvd_q[NW-1]} - {2'b00, den_q};
		take  = !trial[DVW+1];
	end

	// cruise clamp, ramp selection and step-end checks
	always_comb begin
		cruise_lim   = (cruise_q > ceil_q) ? ceil_q : cruise_q;
		cruise_clamp = (cruise_lim < startf_q) ? startf_q : cruise_lim;
		span         = (clamp_q >= startf_q) ? (clamp_q - startf_q) : '0;
		in_up        = (ramp_q != '0) && (step_q < C'(ramp_q));
		in_dn        = (ramp_q != '0) && !in_up &&
		               (((C+1)'(step_q) + (C+1)'(ramp_q)) > (C+1)'(total_q));
		rem_steps    = (total_q > step_q) ? (total_q - step_q) : '0;
		mul_x        = in_up ? step_q[RW-1:0] : rem_steps[RW-1:0];
		timer_dec    = (timer_q != '0) ? (timer_q - C'(1)) : '0;
		last_step    = (((C+1)'(step_q) + (C+1)'(1)) >= (C+1)'(total_q)) ||
		               (step_q == {C{1'b1}});
		ramp_freq    = startf_q + quo_q[F-1:0];
		cruise_fix   = (clamp_q == '0) ? F'(1) : clamp_q;
		half_ticks   = (quo_q[C-1:0] == '0) ? C'(1) : quo_q[C-1:0];
	end

	// sequencer, move state, divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= C'(stpg_pkg::RST_TOTAL_STEPS);
			cruise_q     <= F'(stpg_pkg::RST_CRUISE_FREQ);
			dir_q        <= 1'b1;
			startf_q     <= F'(stpg_pkg::RST_START_FREQ);
			ramp_q       <= RW'(stpg_pkg::RST_RAMP_STEPS);
			ceil_q       <= F'(stpg_pkg::RST_FREQ_CEIL);
			num_q        <= C'(stpg_pkg::RST_HALF_NUM);
			running_q    <= 1'b0;
			phase_q      <= 1'b0;
			step_q       <= '0;
			timer_q      <= '0;
			hpt_q        <= '0;
			clamp_q      <= '0;
			freq_q       <= '0;
			tick_after_q <= 1'b0;
			res_pulse_q  <= 1'b0;
			res_busy_q   <= 1'b0;
			res_done_q   <= 1'b0;
			res_idx_q    <= '0;
			res_freq_q   <= '0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
			dvd_q        <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			prod_q       <= '0;
		end else begin
			// config writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					stpg_pkg::REG_TOTAL_STEPS: total_q  <= cfg_data[C-1:0];
					stpg_pkg::REG_CRUISE_FREQ: cruise_q <= cfg_data[F-1:0];
					stpg_pkg::REG_DIRECTION:   dir_q    <= cfg_data[0];
					stpg_pkg::REG_START_FREQ:  startf_q <= cfg_data[F-1:0];
					stpg_pkg::REG_RAMP_STEPS:  ramp_q   <= cfg_data[RW-1:0];
					stpg_pkg::REG_FREQ_CEIL:   ceil_q   <= cfg_data[F-1:0];
					stpg_pkg::REG_HALF_NUM:    num_q    <= cfg_data[C-1:0];
					default: ;
				endcase
			end

			// output drain
			if (m_valid_q && m_tready && !out_load) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!running_q && start_req && total_q != '0) begin
							clamp_q      <= cruise_clamp;
							running_q    <= 1'b1;
							step_q       <= '0;
							tick_after_q <= 1'b1;
							state_q      <= S_PICK;
						end else if (running_q) begin
							state_q <= S_TICK;
						end else begin
							// idle tick; zero-length move reports done
							res_pulse_q <= 1'b0;
							res_busy_q  <= 1'b0;
							res_done_q  <= start_req;
							res_idx_q   <= '0;
							res_freq_q  <= '0;
							state_q     <= S_PUSH;
						end
					end
				end

				S_TICK: begin
					res_pulse_q <= phase_q;
					res_busy_q  <= 1'b1;
					res_done_q  <= (timer_dec == '0) && !phase_q && last_step;
					res_idx_q   <= step_q;
					res_freq_q  <= freq_q;
					if (timer_dec != '0) begin
						timer_q <= timer_dec;
						state_q <= S_PUSH;
					end else if (phase_q) begin
						// high half over, low half starts
						phase_q <= 1'b0;
						timer_q <= hpt_q;
						state_q <= S_PUSH;
					end else if (last_step) begin
						running_q <= 1'b0;
						timer_q   <= '0;
						state_q   <= S_PUSH;
					end else begin
						step_q       <= step_q + C'(1);
						timer_q      <= '0;
						tick_after_q <= 1'b0;
						state_q      <= S_PICK;
					end
				end

				// ramp or cruise frequency for step_q
				S_PICK: begin
					if (in_up || in_dn) begin
						prod_q  <= NW1'(span) * NW1'(mul_x);
						state_q <= S_LD1;
					end else begin
						freq_q  <= cruise_fix;
						dvd_q   <= NW'(num_q) << (NW - C);
						den_q   <= DVW'(cruise_fix);
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= CW'(C);
						state_q <= S_DIV2;
					end
				end

				S_LD1: begin
					dvd_q   <= NW'(prod_q) << (NW - NW1);
					den_q   <= DVW'(ramp_q);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= CW'(NW1);
					state_q <= S_DIV1;
				end

				S_DIV1, S_DIV2: begin
					dvd_q <= {dvd_q[NW-2:0], 1'b0};
					quo_q <= {quo_q[NW-2:0], take};
					rem_q <= take ? trial[DVW-1:0] : {rem_q[DVW-2:0], dvd_q[NW-1]};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= (state_q == S_DIV1) ? S_FREQ : S_HALF;
					end
				end

				// ramp frequency done, now the half period
				S_FREQ: begin
					freq_q  <= (ramp_freq == '0) ? F'(1) : ramp_freq;
					dvd_q   <= NW'(num_q) << (NW - C);
					den_q   <= DVW'((ramp_freq == '0) ? F'(1) : ramp_freq);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= CW'(C);
					state_q <= S_DIV2;
				end

				S_HALF: begin
					hpt_q   <= half_ticks;
					timer_q <= half_ticks;
					phase_q <= 1'b1;
					state_q <= tick_after_q ? S_TICK : S_PUSH;
				end

				S_PUSH: begin
					if (out_load) begin
						m_valid_q <= 1'b1;
						m_data_q  <= OW'({res_freq_q, res_idx_q, res_done_q, res_busy_q,
						                  dir_q, res_pulse_q});
						state_q   <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 || state_q == S_DIV2) |-> (den_q != '0))
		else $error("divider running with zero divisor");

	a_busy_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_data_q[2]) |-> (m_data_q[4+C +: F] != '0))
		else $error("busy result with zero step frequency");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_data_q[2]) |-> (!m_data_q[0] && m_data_q[4 +: C] == '0))
		else $error("idle result with pulse or step index");

	a_tick_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK) |-> (running_q && hpt_q != '0))
		else $error("tick processed without a valid half period");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == S_IDLE && m_valid_q))
		else $error("result load did not return to idle");

endmodule

`default_nettype wire
